@@ sv/i2cm_pkg.sv @@
// Package for the I2C master transaction engine: widths, codes, phases.
// No dependencies.
`timescale 1ns / 1ps
package i2cm_pkg;
  localparam int FifoDepth = 16;
  localparam int FifoAw = $clog2(FifoDepth);
  localparam int FillW = $clog2(FifoDepth + 1);
  localparam logic [12:0] HalfMax = 13'd4096;

  typedef enum logic [1:0] {ACT_TICK = 2'd0, ACT_START = 2'd1, ACT_PUSH = 2'd2,
                            ACT_NONE = 2'd3} action_t;
  typedef enum logic [1:0] {ERR_NONE = 2'd0, ERR_NAK = 2'd1, ERR_TIMEOUT = 2'd2,
                            ERR_ARB = 2'd3} err_t;
  typedef enum logic [1:0] {K_ADDR_W = 2'd0, K_DATA_W = 2'd1, K_ADDR_R = 2'd2,
                            K_DATA_R = 2'd3} kind_t;
  typedef enum logic [4:0] {
    P_IDLE, P_SA_UP, P_SA_CHK, P_SA_LOW, P_SA_SCL, P_SA_DONE,
    P_B_SETUP, P_B_SCLUP, P_B_SCLCHK, P_B_SAMPLE, P_B_END,
    P_RS_UP, P_RS_CHK, P_RS_SCLUP, P_RS_SCLCHK,
    P_SP_LOW, P_SP_SCLUP, P_SP_SCLCHK, P_SP_SDAUP, P_SP_SDACHK, P_SP_END
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] target_address;
    logic [4:0] write_count;
    logic [7:0] read_count;
    logic       allow_last_nak;
    logic       nak_last_read;
    logic [7:0] data_byte;
    logic       sda_level;
    logic       scl_level;
  } in_item_t;

  typedef struct packed {
    logic       sda_release;
    logic       scl_release;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic       success;
    logic [1:0] error_code;
  } out_item_t;
endpackage

@@ sv/i2cm_fifo.sv @@
// Write-byte FIFO of the I2C engine, flip-flop storage, same-cycle read.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
module i2cm_fifo import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] push_data,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] head_data
);
  logic [7:0] mem [FifoDepth];
  logic [FifoAw-1:0] head, tail;
  logic [FillW-1:0] fill;
  logic do_push, do_pop;

  assign do_push = push && (fill < FillW'(FifoDepth));
  // a push into an empty FIFO is visible to a pop on the same tick
  assign empty = (fill == '0) && !push;
  assign do_pop = pop && !empty;
  assign head_data = (fill == '0) ? push_data : mem[head];

  always_ff @(posedge clk) begin
    if (do_push) mem[tail] <= push_data;
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (do_push) tail <= (tail == FifoAw'(FifoDepth - 1)) ? '0 : tail + 1'b1;
      if (do_pop) head <= (head == FifoAw'(FifoDepth - 1)) ? '0 : head + 1'b1;
      fill <= fill + FillW'(do_push) - FillW'(do_pop);
    end
  end
endmodule

@@ sv/i2cm_engine.sv @@
// Bus sequencer of the I2C engine: one pass of the state machine per tick.
// Depends on i2cm_pkg; reads the FIFO head and its empty flag.
`timescale 1ns / 1ps
module i2cm_engine import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  in_item_t   item,
  input  logic [12:0] half_period_ticks,
  input  logic [7:0] max_stretch_tries,
  input  logic       fifo_empty,
  input  logic [7:0] fifo_data,
  output logic       fifo_pop,
  output out_item_t  res
);
  phase_t     phase, phase_next;
  logic [11:0] delay_count, delay_next;
  logic [7:0] stretch_count, stretch_next;
  logic [3:0] bit_index, bit_next;
  logic [7:0] shift_byte, shift_next;
  logic [4:0] writes_left, writes_next;
  logic [7:0] reads_left, reads_next;
  logic [1:0] pending, pending_next;
  logic [1:0] line_drive, line_next;
  logic [6:0] addr_latch, addr_next;
  logic       allow_latch, allow_next, nakr_latch, nakr_next;
  logic       ack_bit, ack_next, write_done, wdone_next;
  kind_t      kind, kind_next;
  out_item_t  r;
  logic [11:0] h_m1;
  logic [7:0] tries;
  logic       sda, scl, go, rx, txv, popped, empty_now;

  assign sda = item.sda_level;
  assign scl = item.scl_level;
  assign fifo_pop = popped;

  always_comb begin
    if (half_period_ticks == 13'd0) h_m1 = 12'd0;
    else if (half_period_ticks > HalfMax) h_m1 = 12'd4095;
    else h_m1 = 12'(half_period_ticks - 13'd1);
    tries = (max_stretch_tries == 8'd0) ? 8'd1 : max_stretch_tries;
  end

  // Unrolled run loop: each phase either returns or falls into another;
  // the chain of immediate transitions is short (at most eight hops).
  always_comb begin
    phase_next = phase; delay_next = delay_count; stretch_next = stretch_count;
    bit_next = bit_index; shift_next = shift_byte; writes_next = writes_left;
    reads_next = reads_left; pending_next = pending; line_next = line_drive;
    addr_next = addr_latch; allow_next = allow_latch; nakr_next = nakr_latch;
    ack_next = ack_bit; wdone_next = write_done; kind_next = kind;
    r = '0; popped = 1'b0; go = 1'b0; rx = 1'b0; txv = 1'b0;
    empty_now = fifo_empty;
    if (step) begin
      if (phase != P_IDLE) begin
        if (delay_count != 12'd0) delay_next = delay_count - 12'd1;
        else go = 1'b1;
      end else if (item.action == ACT_START) begin
        addr_next = item.target_address; writes_next = item.write_count;
        reads_next = item.read_count; allow_next = item.allow_last_nak;
        nakr_next = item.nak_last_read; pending_next = '0; wdone_next = 1'b0;
        stretch_next = '0; bit_next = '0; phase_next = P_SA_UP; go = 1'b1;
      end
    end
    for (int it = 0; it < 8; it++) begin
      if (go) begin
        go = 1'b0;
        rx = (kind_next == K_DATA_R) ? (bit_next < 4'd8) : (bit_next == 4'd8);
        txv = (kind_next == K_DATA_R) ? (reads_next == 8'd0 && nakr_next)
                                      : shift_next[7];
        unique case (phase_next)
          P_SA_UP: begin
            line_next[0] = 1'b1; delay_next = h_m1; phase_next = P_SA_CHK;
          end
          P_SA_CHK: begin
            if (!sda) begin
              if (wdone_next) begin
                if (pending_next == 2'd0) pending_next = ERR_ARB;
                phase_next = P_SP_LOW; go = 1'b1;
              end else begin
                r.done_res = 1'b1; r.error_code = (pending_next != 2'd0) ? pending_next
                                                                         : ERR_ARB;
                r.success = 1'b0; phase_next = P_IDLE;
              end
            end else begin
              delay_next = h_m1; phase_next = P_SA_LOW;
            end
          end
          P_SA_LOW: begin
            line_next[0] = 1'b0; delay_next = h_m1; phase_next = P_SA_SCL;
          end
          P_SA_SCL: begin
            line_next[1] = 1'b0; delay_next = h_m1; phase_next = P_SA_DONE;
          end
          P_SA_DONE: begin
            if (!wdone_next && (writes_next != 5'd0 || reads_next == 8'd0)) begin
              kind_next = K_ADDR_W; shift_next = {addr_next, 1'b0};
            end else begin
              kind_next = K_ADDR_R; shift_next = {addr_next, 1'b1};
            end
            bit_next = '0; phase_next = P_B_SETUP; go = 1'b1;
          end
          P_B_SETUP: begin
            line_next[0] = rx ? 1'b1 : txv; delay_next = h_m1; phase_next = P_B_SCLUP;
          end
          P_B_SCLUP, P_RS_SCLUP, P_SP_SCLUP: begin
            line_next[1] = 1'b1; stretch_next = '0; delay_next = h_m1;
            phase_next = (phase_next == P_B_SCLUP) ? P_B_SCLCHK :
                         (phase_next == P_RS_SCLUP) ? P_RS_SCLCHK : P_SP_SCLCHK;
          end
          P_B_SCLCHK, P_RS_SCLCHK, P_SP_SCLCHK: begin
            if (scl) begin
              delay_next = h_m1;
              phase_next = (phase_next == P_B_SCLCHK) ? P_B_SAMPLE :
                           (phase_next == P_RS_SCLCHK) ? P_SA_UP : P_SP_SDAUP;
            end else if (9'(stretch_next) + 9'd1 >= 9'(tries)) begin
              if (phase_next == P_SP_SCLCHK) begin
                r.done_res = 1'b1;
                r.error_code = (pending_next != 2'd0) ? pending_next : ERR_TIMEOUT;
                phase_next = P_IDLE;
              end else begin
                if (pending_next == 2'd0) pending_next = ERR_TIMEOUT;
                phase_next = P_SP_LOW; go = 1'b1;
              end
            end else begin
              stretch_next = stretch_next + 8'd1; delay_next = h_m1;
            end
          end
          P_B_SAMPLE: begin
            if (rx) begin
              if (bit_next < 4'd8) shift_next = {shift_next[6:0], sda};
              else ack_next = sda;
              line_next[1] = 1'b0; phase_next = P_B_END; go = 1'b1;
            end else if (txv && !sda) begin
              if (pending_next == 2'd0) pending_next = ERR_ARB;
              phase_next = P_SP_LOW; go = 1'b1;
            end else begin
              line_next[1] = 1'b0; delay_next = h_m1; phase_next = P_B_END;
            end
          end
          P_B_END: begin
            if (kind_next != K_DATA_R && bit_next < 4'd8)
              shift_next = {shift_next[6:0], 1'b0};
            bit_next = bit_next + 4'd1;
            go = 1'b1;
            if (bit_next < 4'd9) phase_next = P_B_SETUP;
            else begin
              case (kind_next)
                K_ADDR_W, K_DATA_W: begin
                  if (ack_next && (kind_next == K_ADDR_W || writes_next != 5'd0
                                   || !allow_next)) begin
                    if (pending_next == 2'd0) pending_next = ERR_NAK;
                    phase_next = P_SP_LOW;
                  end else if (writes_next != 5'd0) begin
                    writes_next = writes_next - 5'd1;
                    kind_next = K_DATA_W;
                    shift_next = empty_now ? 8'd0 : fifo_data;
                    popped = !empty_now;
                    bit_next = '0; phase_next = P_B_SETUP;
                  end else begin
                    wdone_next = 1'b1;
                    phase_next = (reads_next != 8'd0) ? P_RS_UP : P_SP_LOW;
                  end
                end
                K_ADDR_R: begin
                  if (ack_next) begin
                    if (pending_next == 2'd0) pending_next = ERR_NAK;
                    phase_next = P_SP_LOW;
                  end else begin
                    if (reads_next != 8'd0) reads_next = reads_next - 8'd1;
                    kind_next = K_DATA_R; shift_next = '0; bit_next = '0;
                    phase_next = P_B_SETUP;
                  end
                end
                default: begin
                  r.read_byte = shift_next; r.read_valid = 1'b1;
                  if (reads_next != 8'd0) begin
                    reads_next = reads_next - 8'd1;
                    kind_next = K_DATA_R; shift_next = '0; bit_next = '0;
                    phase_next = P_B_SETUP;
                  end else phase_next = P_SP_LOW;
                end
              endcase
            end
          end
          P_RS_UP: begin
            line_next[0] = 1'b1; delay_next = h_m1; phase_next = P_RS_CHK;
          end
          P_RS_CHK: begin
            if (!sda) begin
              if (pending_next == 2'd0) pending_next = ERR_ARB;
              phase_next = P_SP_LOW; go = 1'b1;
            end else begin
              delay_next = h_m1; phase_next = P_RS_SCLUP;
            end
          end
          P_SP_LOW: begin
            line_next[0] = 1'b0; delay_next = h_m1; phase_next = P_SP_SCLUP;
          end
          P_SP_SDAUP: begin
            line_next[0] = 1'b1; delay_next = h_m1; phase_next = P_SP_SDACHK;
          end
          P_SP_SDACHK: begin
            if (!sda) begin
              r.done_res = 1'b1;
              r.error_code = (pending_next != 2'd0) ? pending_next : ERR_ARB;
              phase_next = P_IDLE;
            end else begin
              delay_next = h_m1; phase_next = P_SP_END;
            end
          end
          P_SP_END: begin
            r.done_res = 1'b1; r.error_code = pending_next;
            r.success = (pending_next == 2'd0); phase_next = P_IDLE;
          end
          default: phase_next = P_IDLE;
        endcase
      end
    end
    r.sda_release = line_next[0];
    r.scl_release = line_next[1];
    r.busy_res = (phase_next != P_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE; delay_count <= '0; stretch_count <= '0; bit_index <= '0;
      shift_byte <= '0; writes_left <= '0; reads_left <= '0; pending <= '0;
      line_drive <= 2'b11; addr_latch <= '0; allow_latch <= 1'b0;
      nakr_latch <= 1'b0; ack_bit <= 1'b0; write_done <= 1'b0; kind <= K_ADDR_W;
      res <= '0;
    end else if (step) begin
      phase <= phase_next; delay_count <= delay_next; stretch_count <= stretch_next;
      bit_index <= bit_next; shift_byte <= shift_next; writes_left <= writes_next;
      reads_left <= reads_next; pending <= pending_next; line_drive <= line_next;
      addr_latch <= addr_next; allow_latch <= allow_next; nakr_latch <= nakr_next;
      ack_bit <= ack_next; write_done <= wdone_next; kind <= kind_next;
      res <= r;
    end
  end
endmodule

@@ sv/i2c_master_transaction_engine.sv @@
// Top level of the I2C master transaction engine: stream ports, config,
// input unpacking, FIFO and sequencer. Depends on i2cm_pkg, i2cm_fifo, i2cm_engine.
//
// Usage: each input transaction on s_axis is one bus tick carrying an action
// (tick, start, push write byte), start parameters and sampled SDA/SCL.
// Every accepted tick gives exactly one result on m_axis: line drives,
// received byte, busy/done, success and error code.
// The result of a tick is held in the sequencer result register, then moved
// to the output register, possibly by way of the skid slot. Throughput: one tick
// per cycle while s_axis_tready is high, set by the single sequencer pass.
// A finished result may wait in the output register while the next one is
// moved into a skid slot; s_axis_tready drops while the skid slot is full
// and a further result still waits in the sequencer register.
// Reset (rst, synchronous) returns to idle with both lines released, empty FIFO,
// half period 48 ticks and stretch limit 64. The config port (cfg_we, cfg_index,
// cfg_data) is for the user to write only when idle; the block does not enforce it.
`timescale 1ns / 1ps
module i2c_master_transaction_engine import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[1:0], target_address[8:2], write_count[13:9], read_count[21:14],
  // allow_last_nak[22], nak_last_read[23], data_byte[31:24], sda_level[32],
  // scl_level[33], zero fill to 40
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sda_release[0], scl_release[1], read_byte[9:2], read_valid[10],
  // busy_res[11], done_res[12], success[13], error_code[15:14]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  logic [12:0] half_period_ticks;
  logic [7:0]  max_stretch_tries;
  in_item_t    item;
  out_item_t   res, skid, out_reg;
  logic        out_full, skid_full, step, in_acc, out_take, res_new;
  logic        fifo_pop, fifo_empty;
  logic [7:0]  fifo_data;

  function automatic logic [15:0] res_eff_pad(input out_item_t o);
    res_eff_pad = {o.error_code, o.success, o.done_res, o.busy_res, o.read_valid,
                   o.read_byte, o.scl_release, o.sda_release};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= 13'd48;
      max_stretch_tries <= 8'd64;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) half_period_ticks <= cfg_data;
      else max_stretch_tries <= cfg_data[7:0];
    end
  end

  assign item = in_item_t'({s_axis_tdata[1:0], s_axis_tdata[8:2], s_axis_tdata[13:9],
                            s_axis_tdata[21:14], s_axis_tdata[22], s_axis_tdata[23],
                            s_axis_tdata[31:24], s_axis_tdata[32], s_axis_tdata[33]});

  // a new tick would overwrite res, so hold off while res cannot move on
  assign s_axis_tready = !(res_new && skid_full);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;
  assign step = in_acc;

  i2cm_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(step && item.action == ACT_PUSH), .push_data(item.data_byte),
    .pop(fifo_pop), .empty(fifo_empty), .head_data(fifo_data)
  );

  i2cm_engine u_engine (
    .clk(clk), .rst(rst), .step(step), .item(item),
    .half_period_ticks(half_period_ticks), .max_stretch_tries(max_stretch_tries),
    .fifo_empty(fifo_empty), .fifo_data(fifo_data), .fifo_pop(fifo_pop), .res(res)
  );

  // res holds the newest result in the cycle after step; out/skid queue it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_new <= 1'b0; out_full <= 1'b0; skid_full <= 1'b0;
    end else begin
      res_new <= step || (res_new && skid_full && !out_take);
      if (out_take) begin
        if (skid_full) begin
          out_reg <= skid; skid_full <= res_new;
          if (res_new) skid <= res;
        end else if (res_new) out_reg <= res;
        else out_full <= 1'b0;
      end else if (res_new && !skid_full) begin
        if (!out_full) begin
          out_reg <= res; out_full <= 1'b1;
        end else begin
          skid <= res; skid_full <= 1'b1;
        end
      end
    end
  end
  // Stall rule: with output and skid full, a result in res waits there and
  // tready stays low until the skid slot drains.
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata = res_eff_pad(out_reg);

  assert property (@(posedge clk) disable iff (rst) skid_full |-> out_full)
    else $error("skid holds data while output is empty");
  assert property (@(posedge clk) disable iff (rst)
                   (out_full && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (rst)
                   m_axis_tvalid && m_axis_tdata[12] |-> !m_axis_tdata[11])
    else $error("done reported while still busy");
endmodule
